// ===== design/hswir_pkg.sv =====
// ----------------------------------------------------------------------------
// hswir_pkg
// Shared types and constants for the handle stack: request and response
// payloads, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package hswir_pkg;

   localparam int DEPTH_DEF       = 128;
   localparam int HANDLE_BITS_DEF = 32;

   localparam int FUNC_W     = 3;
   localparam int HANDLE_W   = 32;
   localparam int POS_W      = 7;
   localparam int STATUS_W   = 3;
   localparam int FILL_W     = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH       = 3'd0,
      FUNC_POP_TOP    = 3'd1,
      FUNC_POP_INDEX  = 3'd2,
      FUNC_REMOVE     = 3'd3,
      FUNC_PEEK_TOP   = 3'd4,
      FUNC_PEEK_INDEX = 3'd5,
      FUNC_OVERWRITE  = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [HANDLE_W-1:0] handle_in;
      logic [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle_out;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

   // read address source
   typedef enum logic [1:0] {
      RD_TOP,
      RD_POS,
      RD_ZERO,
      RD_NEXT
   } rd_sel_type;

   // write address/data source
   typedef enum logic [1:0] {
      WR_PUSH,
      WR_POS,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_POS,
      IDX_NEXT
   } idx_op_type;

   typedef enum logic [1:0] {
      OCC_HOLD,
      OCC_INC,
      OCC_DEC
   } occ_op_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      idx_op_type idx_op;
      occ_op_type occ_op;
      logic       load_got;
      logic       finish;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              pos_bad;
      logic              at_last;
      logic              match;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/handle_stack_with_indexed_removal.sv =====
// ----------------------------------------------------------------------------
// handle_stack_with_indexed_removal
// Bounded stack of handles with push, pop, indexed pop, remove-by-value,
// peek, indexed peek and overwrite. One response per request.
//
//   channel   handshake            payload
//   request   start / busy         req_data  (func, handle_in, position)
//   response  rsp_strobe (1 cyc)   rsp_data  (handle_out, status, fill_count)
//
// Push, overwrite, unused code and any rejected request finish straight from
// decode. Pop/peek top and peek index read the entry first. Pop at index p
// shifts the entries above p down, one shift per cycle through the single RAM read port.
// Remove value scans to the match, then shifts; with no match it scans the whole
// stack. Reset clears the fill count, response strobe and controller state; RAM is never read
// unwritten. busy stays high until the response strobe; receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_stack_with_indexed_removal import hswir_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   hswir_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   hswir_dp #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a transaction never completes in the cycle right after it was taken
   a_no_same_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("response strobe directly after accept");

   // busy drops exactly with the response
   a_busy_drop_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without a response");

   // failed requests return no handle
   a_err_zero_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.handle_out == '0))
      else $error("handle returned on failed request");

   // no shift or fetch activity while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!cmd.wr_en && !cmd.rd_en && !cmd.finish))
      else $error("datapath command while idle");
`endif

endmodule

`default_nettype wire

// ===== design/hswir_ram.sv =====
// ----------------------------------------------------------------------------
// hswir_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hswir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/hswir_dp.sv =====
// ----------------------------------------------------------------------------
// hswir_dp
// Datapath: request register, fill count, walk index, handle RAM and the
// response register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module hswir_dp import hswir_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [FUNC_W-1:0]      func_ff;
   logic [HANDLE_BITS-1:0] val_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [HANDLE_W-1:0]    got_ff, got_in;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_data_ff;

   logic [ADDR_W-1:0]      top_addr, pos_addr, idx_next;
   logic                   rd_en, wr_en;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic [HANDLE_BITS-1:0] wr_data, rd_data;

   assign top_addr = ADDR_W'(occ_ff - CNT_W'(1));
   assign pos_addr = ADDR_W'(pos_ff);
   assign idx_next = ADDR_W'(idx_ff + ADDR_W'(1));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TOP:  rd_addr = top_addr;
         RD_POS:  rd_addr = pos_addr;
         RD_ZERO: rd_addr = '0;
         RD_NEXT: rd_addr = idx_next;
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_PUSH: begin
            wr_addr = ADDR_W'(occ_ff);
            wr_data = val_ff;
         end
         WR_POS: begin
            wr_addr = pos_addr;
            wr_data = val_ff;
         end
         WR_SHIFT: begin
            // close the gap: entry idx moves down one slot
            wr_addr = ADDR_W'(idx_ff - ADDR_W'(1));
            wr_data = rd_data;
         end
         default: begin
            wr_addr = '0;
            wr_data = val_ff;
         end
      endcase
   end

   assign rd_en = cmd.rd_en;
   assign wr_en = cmd.wr_en;

   hswir_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (cmd.occ_op)
         OCC_INC: occ_in = occ_ff + CNT_W'(1);
         OCC_DEC: occ_in = occ_ff - CNT_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_POS:  idx_in = pos_addr;
         IDX_NEXT: idx_in = idx_next;
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      priority if (cmd.load_got) begin
         got_in = HANDLE_W'(rd_data);
      end else if (cmd.load_req) begin
         got_in = '0;
      end else begin
         got_in = got_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         occ_ff        <= occ_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_data.func;
         val_ff  <= HANDLE_BITS'(req_data.handle_in);
         pos_ff  <= req_data.position;
      end
      idx_ff <= idx_in;
      got_ff <= got_in;
      if (cmd.finish) begin
         rsp_data_ff.handle_out <= got_in;
         rsp_data_ff.status     <= cmd.status;
         rsp_data_ff.fill_count <= FILL_W'(occ_in);
      end
   end

   assign stat.func    = func_ff;
   assign stat.empty   = (occ_ff == '0);
   assign stat.full    = (occ_ff == CNT_W'(DEPTH));
   assign stat.pos_bad = (CMP_W'(pos_ff) >= CMP_W'(occ_ff));
   assign stat.at_last = (idx_ff == top_addr);
   assign stat.match   = (rd_data == val_ff);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/hswir_ctrl.sv =====
// ----------------------------------------------------------------------------
// hswir_ctrl
// Controller: decodes the captured request, sequences reads, scan and
// shift passes through the handle RAM and issues the finish command.
// ----------------------------------------------------------------------------
`default_nettype none

module hswir_ctrl import hswir_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          busy,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_SCAN,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '{load_req: 1'b0, rd_en: 1'b0, rd_sel: RD_ZERO, wr_en: 1'b0,
                   wr_sel: WR_PUSH, idx_op: IDX_HOLD, occ_op: OCC_HOLD,
                   load_got: 1'b0, finish: 1'b0, status: ST_OK};
      state_in = state_ff;
      busy_in  = busy_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
               busy_in      = 1'b1;
            end
         end

         S_DECODE: begin
            unique case (stat.func)
               FUNC_PUSH: begin
                  cmd.finish = 1'b1;
                  if (stat.full) begin
                     cmd.status = ST_OVERFLOW;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_PUSH;
                     cmd.occ_op = OCC_INC;
                  end
               end
               FUNC_POP_TOP, FUNC_PEEK_TOP: begin
                  if (stat.empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_UNDERFLOW;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_TOP;
                     state_in   = S_FETCH;
                  end
               end
               FUNC_POP_INDEX, FUNC_PEEK_INDEX: begin
                  priority if (stat.empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_UNDERFLOW;
                  end else if (stat.pos_bad) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_BAD_INDEX;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     cmd.idx_op = IDX_POS;
                     state_in   = S_FETCH;
                  end
               end
               FUNC_REMOVE: begin
                  if (stat.empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_NOT_FOUND;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_SCAN;
                  end
               end
               FUNC_OVERWRITE: begin
                  cmd.finish = 1'b1;
                  if (stat.pos_bad) begin
                     cmd.status = ST_BAD_INDEX;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_POS;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
               end
            endcase
         end

         S_FETCH: begin
            cmd.load_got = 1'b1;
            priority if (stat.func == FUNC_POP_TOP) begin
               cmd.occ_op = OCC_DEC;
               cmd.finish = 1'b1;
            end else if (stat.func == FUNC_POP_INDEX && !stat.at_last) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               cmd.idx_op = IDX_NEXT;
               state_in   = S_SHIFT;
            end else if (stat.func == FUNC_POP_INDEX) begin
               // removing the top entry: nothing to move
               cmd.occ_op = OCC_DEC;
               cmd.finish = 1'b1;
            end else begin
               cmd.finish = 1'b1;
            end
         end

         S_SCAN: begin
            // read data holds the entry at idx
            priority if (stat.match && stat.at_last) begin
               cmd.occ_op = OCC_DEC;
               cmd.finish = 1'b1;
            end else if (stat.match) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               cmd.idx_op = IDX_NEXT;
               state_in   = S_SHIFT;
            end else if (stat.at_last) begin
               cmd.finish = 1'b1;
               cmd.status = ST_NOT_FOUND;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               cmd.idx_op = IDX_NEXT;
            end
         end

         S_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            if (stat.at_last) begin
               cmd.occ_op = OCC_DEC;
               cmd.finish = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               cmd.idx_op = IDX_NEXT;
            end
         end

         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase

      if (cmd.finish) begin
         state_in = S_IDLE;
         busy_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the handle stack. Directed tests cover the empty and full
// stack, every operation and each rejected request. Random tests then run
// request mixes with and without idle gaps on the request side. A local
// stack tracks every accepted transaction and predicts its response. Each
// response strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hswir_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEF;
   localparam int GAP_MAX = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
   localparam int PRINT_MAX = 50;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // local copy of the stack
   logic [HANDLE_W-1:0] stack_mem [STACK_DEPTH];
   int                  stack_fill;

   rsp_type pending_rsp [$];
   int      err_count;
   int      quiet_cycles;

   handle_stack_with_indexed_removal u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic void close_gap(int at);
      for (int k = at; k + 1 < stack_fill; k++) begin
         stack_mem[k] = stack_mem[k + 1];
      end
      stack_fill--;
   endfunction

   function automatic rsp_type stack_predict(req_type r);
      rsp_type res;
      bit      hit;
      res = '0;
      res.status = ST_OK;
      hit = 1'b0;
      case (r.func)
         FUNC_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               stack_mem[stack_fill] = r.handle_in;
               stack_fill++;
            end
         end
         FUNC_POP_TOP, FUNC_PEEK_TOP: begin
            if (stack_fill == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.handle_out = stack_mem[stack_fill - 1];
               if (r.func == FUNC_POP_TOP) stack_fill--;
            end
         end
         FUNC_POP_INDEX, FUNC_PEEK_INDEX: begin
            if (stack_fill == 0) begin
               res.status = ST_UNDERFLOW;
            end else if (int'(r.position) >= stack_fill) begin
               res.status = ST_BAD_INDEX;
            end else begin
               res.handle_out = stack_mem[r.position];
               if (r.func == FUNC_POP_INDEX) close_gap(int'(r.position));
            end
         end
         FUNC_REMOVE: begin
            for (int k = 0; k < stack_fill && !hit; k++) begin
               if (stack_mem[k] == r.handle_in) begin
                  close_gap(k);
                  hit = 1'b1;
               end
            end
            if (!hit) res.status = ST_NOT_FOUND;
         end
         FUNC_OVERWRITE: begin
            if (int'(r.position) >= stack_fill) res.status = ST_BAD_INDEX;
            else stack_mem[r.position] = r.handle_in;
         end
         default: ;
      endcase
      res.fill_count = FILL_W'(stack_fill);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string field, logic [HANDLE_W-1:0] got,
                                  logic [HANDLE_W-1:0] want);
      err_count++;
      if (err_count <= PRINT_MAX) begin
         $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) pending_rsp.push_back(stack_predict(req_data));
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.handle_out, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.handle_out !== want.handle_out)
                  report_mismatch("handle_out", rsp_data.handle_out, want.handle_out);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", HANDLE_W'(rsp_data.status),
                                  HANDLE_W'(want.status));
               if (rsp_data.fill_count !== want.fill_count)
                  report_mismatch("fill_count", HANDLE_W'(rsp_data.fill_count),
                                  HANDLE_W'(want.fill_count));
            end
         end
      end
   end

   // watchdog: cycles in which no transaction moves on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(req_type r, int idle_pct);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         gap++;
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_op(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle,
                          logic [POS_W-1:0] pos);
      req_type r;
      r.func      = func;
      r.handle_in = handle;
      r.position  = pos;
      send_item(r, 0);
   endtask

   task automatic test_empty_stack();
      send_op(FUNC_POP_TOP,    32'h0,        7'd0);
      send_op(FUNC_PEEK_TOP,   32'hFFFFFFFF, 7'd127);
      send_op(FUNC_POP_INDEX,  32'h0,        7'd0);
      send_op(FUNC_PEEK_INDEX, 32'h0,        7'd127);
      send_op(FUNC_OVERWRITE,  32'h1234,     7'd0);
      send_op(FUNC_REMOVE,     32'h0,        7'd0);
      send_op(FUNC_UNUSED,     32'hFFFFFFFF, 7'd127);
   endtask

   task automatic test_basic_ops();
      send_op(FUNC_PUSH,       32'h0,        7'd0);
      send_op(FUNC_PUSH,       32'hFFFFFFFF, 7'd127);
      send_op(FUNC_PUSH,       32'h5,        7'd0);
      send_op(FUNC_PUSH,       32'hA5A5A5A5, 7'd0);
      send_op(FUNC_PEEK_TOP,   32'h0,        7'd0);
      send_op(FUNC_PEEK_INDEX, 32'h0,        7'd0);
      send_op(FUNC_PEEK_INDEX, 32'h0,        7'd4);
      send_op(FUNC_PEEK_INDEX, 32'h0,        7'd127);
      send_op(FUNC_OVERWRITE,  32'h12345678, 7'd1);
      send_op(FUNC_OVERWRITE,  32'h87654321, 7'd4);
      send_op(FUNC_UNUSED,     32'h0,        7'd0);
      send_op(FUNC_POP_INDEX,  32'h0,        7'd1);
      send_op(FUNC_REMOVE,     32'h5,        7'd0);
      send_op(FUNC_REMOVE,     32'hDEADBEEF, 7'd0);
      send_op(FUNC_POP_INDEX,  32'h0,        7'd127);
      send_op(FUNC_POP_TOP,    32'h0,        7'd0);
      send_op(FUNC_POP_TOP,    32'h0,        7'd0);
      send_op(FUNC_POP_TOP,    32'h0,        7'd0);
   endtask

   // fill to the top, then the long shifts and scans
   task automatic test_full_stack();
      logic [HANDLE_W-1:0] base;
      base = $urandom();
      for (int k = 0; k < STACK_DEPTH; k++) begin
         send_op(FUNC_PUSH, base ^ (k * 32'h01010101), 7'd0);
      end
      send_op(FUNC_PUSH,       32'hFFFFFFFF, 7'd127);
      send_op(FUNC_PEEK_INDEX, 32'h0,        7'd127);
      send_op(FUNC_OVERWRITE,  32'h0,        7'd127);
      send_op(FUNC_POP_INDEX,  32'h0,        7'd0);
      send_op(FUNC_REMOVE,     32'h0,        7'd0);
      send_op(FUNC_REMOVE,     ~base,        7'd0);
      send_op(FUNC_PUSH,       32'hFFFFFFFF, 7'd0);
      send_op(FUNC_PUSH,       32'h0,        7'd0);
      send_op(FUNC_REMOVE,     base ^ (7 * 32'h01010101), 7'd0);
      while (stack_fill > 0) send_op(FUNC_POP_TOP, 32'h0, 7'd0);
      send_op(FUNC_POP_TOP, 32'h0, 7'd0);
   endtask

   function automatic logic [HANDLE_W-1:0] pick_handle();
      // a small pool makes duplicates, so remove has to find the first one
      if ($urandom_range(99) < 40)
         return HANDLE_W'($urandom_range(7)) ^ ($urandom_range(1) ? 32'hFFFFFFF8 : 32'h0);
      return $urandom();
   endfunction

   task automatic test_random(int n, int idle_pct);
      req_type r;
      int      target;
      int      sel;
      target = 8;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            target = ($urandom_range(9) == 0) ? STACK_DEPTH : int'($urandom_range(24, 1));
         end
         sel = $urandom_range(99);
         r.handle_in = pick_handle();
         if (stack_fill > 0 && $urandom_range(99) < 85)
            r.position = POS_W'($urandom_range(stack_fill - 1));
         else
            r.position = POS_W'($urandom_range(127));
         if (sel < ((stack_fill < target) ? 50 : 20)) begin
            r.func = FUNC_PUSH;
         end else begin
            sel = $urandom_range(99);
            if (sel < 14)      r.func = FUNC_POP_TOP;
            else if (sel < 30) r.func = FUNC_POP_INDEX;
            else if (sel < 48) r.func = FUNC_REMOVE;
            else if (sel < 58) r.func = FUNC_PEEK_TOP;
            else if (sel < 74) r.func = FUNC_PEEK_INDEX;
            else if (sel < 94) r.func = FUNC_OVERWRITE;
            else               r.func = FUNC_UNUSED;
            if (r.func == FUNC_REMOVE && stack_fill > 0 && $urandom_range(99) < 70)
               r.handle_in = stack_mem[$urandom_range(stack_fill - 1)];
         end
         send_item(r, idle_pct);
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      err_count  = 0;
      stack_fill = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_stack();
      test_basic_ops();
      test_full_stack();
      test_random(500, 0);
      test_random(450, 88);
      test_random(400, 17);

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
